FILE: src/priority_slot_allocator_macros.svh
// ----------------------------------------------------------------------------
// priority_slot_allocator_macros
// Assertion macros shared by the slot allocator RTL.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_SLOT_ALLOCATOR_MACROS_SVH
`define PRIORITY_SLOT_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define PSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg
// Types and constants of the priority slot allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psa_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned LIFE_W = 15;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned IDX_W  = 7;
  localparam int unsigned CNT_W  = 7;

  localparam logic [PRIO_W-1:0] PRIO_RESET = 8'd128;
  localparam logic [IDX_W-1:0]  EIU_RESET  = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // search / tick wave handed from cell to cell
  typedef struct packed {
    logic             tok;
    logic             fh;
    logic [IDX_W-1:0] fh_idx;
    logic             fl;
    logic [IDX_W-1:0] fl_idx;
    logic             dh;
    logic [IDX_W-1:0] dh_idx;
    logic             dl;
    logic [IDX_W-1:0] dl_idx;
    logic [CNT_W-1:0] cnt;
  } carry_t;

  // current request, broadcast to all cells
  typedef struct packed {
    cmd_e              cmd;
    logic [PRIO_W-1:0] prio;
    logic [IDX_W-1:0]  n;
    logic [IDX_W-1:0]  start;
  } req_t;

  // single-slot write, broadcast to all cells
  typedef struct packed {
    logic              en;
    logic              clr;
    logic [IDX_W-1:0]  idx;
    logic [PRIO_W-1:0] prio;
    logic              prot;
    logic [LIFE_W-1:0] life;
  } wr_t;

endpackage

`default_nettype wire

FILE: src/psa_cell.sv
// ----------------------------------------------------------------------------
// psa_cell
// One table slot plus its stage of the search / tick wave.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psa_cell #(
  parameter int unsigned Index = 0
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  psa_pkg::req_t   req_i,
  input  psa_pkg::wr_t    wr_i,
  input  psa_pkg::carry_t carry_i,
  output psa_pkg::carry_t carry_o
);
  import psa_pkg::*;

  localparam logic [31:0]      IdxL  = Index;
  localparam logic [IDX_W-1:0] MyIdx = IdxL[IDX_W-1:0];

  logic              free_q, free_d;
  logic [LIFE_W-1:0] life_q, life_d;
  logic [PRIO_W-1:0] prio_q, prio_d;
  logic              prot_q, prot_d;
  carry_t            carry_q, carry_d;

  logic active;
  logic at_hi;
  logic disp_ok;

  always_comb begin
    active  = IdxL < 32'(req_i.n);
    at_hi   = IdxL >= 32'(req_i.start);
    disp_ok = (req_i.prio < prio_q) || ((req_i.prio == prio_q) && !prot_q);

    carry_d = carry_i;
    free_d  = free_q;
    life_d  = life_q;
    prio_d  = prio_q;
    prot_d  = prot_q;

    if (carry_i.tok && active) begin
      case (req_i.cmd)
        CMD_ALLOC: begin
          if (free_q) begin
            if (at_hi && !carry_i.fh) begin
              carry_d.fh     = 1'b1;
              carry_d.fh_idx = MyIdx;
            end else if (!at_hi && !carry_i.fl) begin
              carry_d.fl     = 1'b1;
              carry_d.fl_idx = MyIdx;
            end
          end
          if (disp_ok) begin
            if (at_hi && !carry_i.dh) begin
              carry_d.dh     = 1'b1;
              carry_d.dh_idx = MyIdx;
            end else if (!at_hi && !carry_i.dl) begin
              carry_d.dl     = 1'b1;
              carry_d.dl_idx = MyIdx;
            end
          end
        end
        CMD_TICK: begin
          if (!free_q) begin
            if (life_q == '0) begin
              free_d      = 1'b1;
              prio_d      = PRIO_RESET;
              prot_d      = 1'b0;
              carry_d.cnt = carry_i.cnt + CNT_W'(1);
            end else begin
              life_d = life_q - LIFE_W'(1);
            end
          end
        end
        default: ;
      endcase
    end

    if (wr_i.en && (32'(wr_i.idx) == IdxL)) begin
      if (wr_i.clr) begin
        free_d = 1'b1;
        prio_d = PRIO_RESET;
        prot_d = 1'b0;
      end else begin
        free_d = 1'b0;
        life_d = wr_i.life;
        prio_d = wr_i.prio;
        prot_d = wr_i.prot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= 1'b1;
      prio_q <= PRIO_RESET;
      prot_q <= 1'b0;
    end else begin
      free_q <= free_d;
      prio_q <= prio_d;
      prot_q <= prot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    life_q <= life_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
    end else begin
      carry_q <= carry_d;
    end
  end

  assign carry_o = carry_q;

endmodule

`default_nettype wire

FILE: src/priority_slot_allocator.sv
// ----------------------------------------------------------------------------
// priority_slot_allocator
// Timed slot table with round-robin allocation and priority replacement.
// ----------------------------------------------------------------------------
// Each slot lives in a cell of a chain; allocate and tick send one token down
// the whole chain, one cell per cycle, and the next transfer is taken only
// once it has left the last cell; free and the unused command skip the chain.
// The result sits in an output register, so a new item is taken while the
// previous result waits. entries_in_use may only be written while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module priority_slot_allocator #(
  parameter int unsigned MaxEntries = psa_pkg::MAX_ENTRIES_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire  [psa_pkg::CMD_W-1:0]       cmd_i,
  input  wire  [psa_pkg::PRIO_W-1:0]      priority_req_i,
  input  wire                             protect_i,
  input  wire  [psa_pkg::LIFE_W-1:0]      lifetime_i,
  input  wire  [psa_pkg::SLOT_W-1:0]      slot_to_free_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic                            status_o,
  output logic [psa_pkg::SLOT_W-1:0]      slot_o,
  output logic                            displaced_o,
  output logic [psa_pkg::CNT_W-1:0]       expired_count_o,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [psa_pkg::IDX_W-1:0]       cfg_entries_in_use_i
);
  import psa_pkg::*;

`include "priority_slot_allocator_macros.svh"

  state_e            state_q, state_d;
  cmd_e              cmd_q, cmd_d;
  logic [PRIO_W-1:0] prio_q, prio_d;
  logic              prot_q, prot_d;
  logic [LIFE_W-1:0] life_q, life_d;
  logic [IDX_W-1:0]  start_q, start_d;
  logic [IDX_W-1:0]  eiu_q;
  logic              launch_q, launch_d;
  logic              res_status_q, res_status_d;
  logic [IDX_W-1:0]  res_idx_q, res_idx_d;
  logic              res_disp_q, res_disp_d;
  logic [CNT_W-1:0]  res_cnt_q, res_cnt_d;
  wr_t               wr_q, wr_d;
  logic              out_valid_q, out_valid_d;
  logic              out_status_q, out_status_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic              out_disp_q, out_disp_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;

  logic [IDX_W-1:0]  n_act;
  logic              accept;
  logic              out_free;
  logic              commit;
  req_t              req;
  wr_t               wr_bus;
  carry_t            head;
  carry_t            last;
  carry_t            chain [MaxEntries];
  logic [MaxEntries-1:0] tok_vec;

  // config register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eiu_q <= EIU_RESET;
    end else if (cfg_valid_i) begin
      eiu_q <= cfg_entries_in_use_i;
    end
  end

  always_comb begin
    if (eiu_q == '0) begin
      n_act = IDX_W'(1);
    end else if (32'(eiu_q) > MaxEntries) begin
      n_act = IDX_W'(MaxEntries);
    end else begin
      n_act = eiu_q;
    end
  end

  // cell chain
  assign req = '{cmd: cmd_q, prio: prio_q, n: n_act, start: start_q};

  always_comb begin
    head     = '0;
    head.tok = launch_q;
  end

  for (genvar g = 0; g < MaxEntries; g++) begin : g_cell
    carry_t cin;
    if (g == 0) begin : g_head
      assign cin = head;
    end else begin : g_link
      assign cin = chain[g-1];
    end
    psa_cell #(
      .Index (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .req_i   (req),
      .wr_i    (wr_bus),
      .carry_i (cin),
      .carry_o (chain[g])
    );
    assign tok_vec[g] = chain[g].tok;
  end

  assign last = chain[MaxEntries-1];

  // control
  assign in_stall_o = state_q != ST_IDLE;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign commit     = (state_q == ST_DONE) && out_free;

  always_comb begin
    wr_bus    = wr_q;
    wr_bus.en = wr_q.en && commit;
  end

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    prio_d       = prio_q;
    prot_d       = prot_q;
    life_d       = life_q;
    start_d      = start_q;
    launch_d     = 1'b0;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    res_disp_d   = res_disp_q;
    res_cnt_d    = res_cnt_q;
    wr_d         = wr_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_disp_d   = out_disp_q;
    out_cnt_d    = out_cnt_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d        = cmd_e'(cmd_i);
          prio_d       = priority_req_i;
          prot_d       = protect_i;
          life_d       = lifetime_i;
          res_status_d = 1'b0;
          res_idx_d    = '0;
          res_disp_d   = 1'b0;
          res_cnt_d    = '0;
          wr_d         = '0;
          case (cmd_e'(cmd_i))
            CMD_ALLOC: begin
              if (start_q >= n_act) begin
                start_d = '0;
              end
              launch_d = 1'b1;
              state_d  = ST_SCAN;
            end
            CMD_TICK: begin
              launch_d = 1'b1;
              state_d  = ST_SCAN;
            end
            CMD_FREE: begin
              wr_d.en  = 1'b1;
              wr_d.clr = 1'b1;
              wr_d.idx = IDX_W'(slot_to_free_i);
              state_d  = ST_DONE;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (last.tok) begin
          if (cmd_q == CMD_ALLOC) begin
            wr_d.en   = 1'b1;
            wr_d.clr  = 1'b0;
            wr_d.prio = prio_q;
            wr_d.prot = prot_q;
            wr_d.life = life_q;
            if (last.fh) begin
              res_idx_d = last.fh_idx;
            end else if (last.fl) begin
              res_idx_d = last.fl_idx;
            end else if (last.dh) begin
              res_idx_d  = last.dh_idx;
              res_disp_d = 1'b1;
            end else if (last.dl) begin
              res_idx_d  = last.dl_idx;
              res_disp_d = 1'b1;
            end else begin
              res_status_d = 1'b1;
              wr_d.en      = 1'b0;
            end
            wr_d.idx = res_idx_d;
          end else begin
            res_cnt_d = last.cnt;
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_idx_q[SLOT_W-1:0];
          out_disp_d   = res_disp_q;
          out_cnt_d    = res_cnt_q;
          if ((cmd_q == CMD_ALLOC) && !res_status_q) begin
            start_d = res_idx_q + IDX_W'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= '0;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
      wr_q        <= '0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      launch_q    <= launch_d;
      out_valid_q <= out_valid_d;
      wr_q        <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    prio_q       <= prio_d;
    prot_q       <= prot_d;
    life_q       <= life_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    res_disp_q   <= res_disp_d;
    res_cnt_q    <= res_cnt_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_disp_q   <= out_disp_d;
    out_cnt_q    <= out_cnt_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign slot_o          = out_slot_q;
  assign displaced_o     = out_disp_q;
  assign expired_count_o = out_cnt_q;

  `PSA_ASSERT_IMP(a_single_token, clk_i, rst_ni, 1'b1, $onehot0(tok_vec), "more than one token in chain")
  `PSA_ASSERT_IMP(a_tok_in_scan, clk_i, rst_ni, last.tok, state_q == ST_SCAN, "token left chain outside scan")
  `PSA_ASSERT_NXT(a_start_moves, clk_i, rst_ni, commit && (cmd_q == CMD_ALLOC) && !res_status_q, start_q != '0, "search start not advanced")
  `PSA_ASSERT_IMP(a_out_from_done, clk_i, rst_ni, $rose(out_valid_o), $past(state_q == ST_DONE), "result without completion")

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the priority slot allocator.
// ----------------------------------------------------------------------------
// A short table of directed commands is walked first: allocation into a fresh
// table, the priority extremes, tick expiry, frees inside and beyond the
// active size, the unused command, equal priority against a protected slot,
// failed allocation and the register clamped at both ends. Random phases
// follow, each with its own table size and command mix, so the table fills
// and replacement kicks in. Results are checked against the directed row or
// a slot-table model in step with each transfer. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  import psa_pkg::*;

  localparam int MAX_SLOTS    = MAX_ENTRIES_DEF;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int PHASE_ITEMS  = 75;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic              status;
    logic [SLOT_W-1:0] slot;
    logic              displaced;
    logic [CNT_W-1:0]  expired;
  } alloc_result_t;

  typedef struct {
    cmd_e              cmd;
    logic [PRIO_W-1:0] prio;
    logic              prot;
    logic [LIFE_W-1:0] life;
    logic [SLOT_W-1:0] victim;
  } slot_cmd_t;

  typedef struct {
    bit               is_cfg;
    logic [IDX_W-1:0] cfg_val;
    slot_cmd_t        cmd;
    bit               typed;
    alloc_result_t    res;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  cmd_e              cmd_drv = CMD_NOP;
  logic [PRIO_W-1:0] prio_drv = '0;
  logic              prot_drv = 1'b0;
  logic [LIFE_W-1:0] life_drv = '0;
  logic [SLOT_W-1:0] free_drv = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              status;
  logic [SLOT_W-1:0] slot;
  logic              displaced;
  logic [CNT_W-1:0]  expired_count;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_data = '0;

  // slot table model
  int               tbl_life [MAX_SLOTS];
  logic [PRIO_W-1:0] tbl_prio [MAX_SLOTS];
  logic             tbl_prot [MAX_SLOTS];
  int               rr_start;
  logic [IDX_W-1:0] cfg_entries;

  alloc_result_t pending_results [$];
  dir_row_t      dir_rows [$];
  logic [IDX_W-1:0] cfg_plan [14] = '{7'd64, 7'd1, 7'd2, 7'd127, 7'd3, 7'd0, 7'd8,
                                      7'd65, 7'd17, 7'd64, 7'd63, 7'd5, 7'd32, 7'd64};

  int errors = 0;
  int cycles = 0;
  bit burst = 1'b0;

  priority_slot_allocator dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall),
    .cmd_i                (cmd_drv),
    .priority_req_i       (prio_drv),
    .protect_i            (prot_drv),
    .lifetime_i           (life_drv),
    .slot_to_free_i       (free_drv),
    .out_valid_o          (out_valid),
    .out_stall_i          (out_stall),
    .status_o             (status),
    .slot_o               (slot),
    .displaced_o          (displaced),
    .expired_count_o      (expired_count),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cfg_entries_in_use_i (cfg_data)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void vacate(int k);
    tbl_life[k] = -1;
    tbl_prio[k] = PRIO_RESET;
    tbl_prot[k] = 1'b0;
  endfunction

  function automatic alloc_result_t slot_table_step(slot_cmd_t c);
    alloc_result_t r;
    int n;
    int i;
    int k;
    bit hit;
    bit live;
    r = '0;
    hit = 1'b0;
    live = 1'b0;
    n = (cfg_entries == 0) ? 1 : ((cfg_entries > MAX_SLOTS) ? MAX_SLOTS : int'(cfg_entries));
    case (c.cmd)
      CMD_ALLOC: begin
        if (rr_start >= n) rr_start = 0;
        i = rr_start;
        for (k = 0; k < n; k++) begin
          if (tbl_life[i] == -1) begin
            hit = 1'b1;
            break;
          end
          i = (i + 1 >= n) ? 0 : i + 1;
        end
        if (!hit) begin
          i = rr_start;
          for (k = 0; k < n; k++) begin
            if (c.prio <= tbl_prio[i] && !(c.prio == tbl_prio[i] && tbl_prot[i])) begin
              hit = 1'b1;
              live = 1'b1;
              break;
            end
            i = (i + 1 >= n) ? 0 : i + 1;
          end
        end
        if (hit) begin
          rr_start = i + 1;
          tbl_life[i] = int'(c.life);
          tbl_prio[i] = c.prio;
          tbl_prot[i] = c.prot;
          r.slot = i[SLOT_W-1:0];
          r.displaced = live;
        end else begin
          r.status = 1'b1;
        end
      end
      CMD_TICK: begin
        for (k = 0; k < n; k++) begin
          if (tbl_life[k] > -1) begin
            tbl_life[k] = tbl_life[k] - 1;
            if (tbl_life[k] < 0) begin
              vacate(k);
              r.expired = r.expired + 1'b1;
            end
          end
        end
      end
      CMD_FREE: begin
        if (int'(c.victim) < MAX_SLOTS) vacate(int'(c.victim));
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic alloc_result_t outcome(logic st, int sl, logic d, int e);
    alloc_result_t r;
    r.status = st;
    r.slot = sl[SLOT_W-1:0];
    r.displaced = d;
    r.expired = e[CNT_W-1:0];
    return r;
  endfunction

  function automatic dir_row_t cmd_row(cmd_e c, int p, logic pr, int lf, int v, bit typed,
                                       alloc_result_t r);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.cfg_val = '0;
    row.cmd.cmd = c;
    row.cmd.prio = p[PRIO_W-1:0];
    row.cmd.prot = pr;
    row.cmd.life = lf[LIFE_W-1:0];
    row.cmd.victim = v[SLOT_W-1:0];
    row.typed = typed;
    row.res = r;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(int v);
    dir_row_t row;
    row = cmd_row(CMD_NOP, 0, 1'b0, 0, 0, 1'b0, '0);
    row.is_cfg = 1'b1;
    row.cfg_val = v[IDX_W-1:0];
    return row;
  endfunction

  function automatic void flag(string msg);
    errors++;
    if (errors <= REPORT_MAX) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  task automatic send(slot_cmd_t c, bit typed, alloc_result_t r);
    int gap;
    alloc_result_t want;
    gap = burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    cmd_drv  <= c.cmd;
    prio_drv <= c.prio;
    prot_drv <= c.prot;
    life_drv <= c.life;
    free_drv <= c.victim;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    want = slot_table_step(c);
    pending_results.push_back(typed ? r : want);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_entries(logic [IDX_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    cfg_entries = v;
  endtask

  // receiver
  initial begin : result_sink
    int n;
    forever begin
      n = burst ? 0 : $urandom_range(0, 12);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk_i) begin : result_check
    alloc_result_t got;
    alloc_result_t want;
    if (rst_ni && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = {status, slot, displaced, expired_count};
      if (pending_results.size() == 0) begin
        flag($sformatf("result with nothing pending: st=%0d slot=%0d disp=%0d exp=%0d",
                       got.status, got.slot, got.displaced, got.expired));
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.slot !== want.slot ||
            got.displaced !== want.displaced || got.expired !== want.expired)
          flag($sformatf("exp st=%0d slot=%0d disp=%0d exp=%0d, got st=%0d slot=%0d disp=%0d exp=%0d",
                         want.status, want.slot, want.displaced, want.expired,
                         got.status, got.slot, got.displaced, got.expired));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL priority_slot_allocator");
      $finish;
    end
  end

  initial begin : stimulus
    slot_cmd_t c;
    alloc_result_t none;
    int j;
    int k;
    int w_tick;
    int draw;
    int life_cap;
    int prio_base;
    none = '0;
    for (k = 0; k < MAX_SLOTS; k++) vacate(k);
    rr_start = 0;
    cfg_entries = EIU_RESET;

    dir_rows.push_back(cmd_row(CMD_ALLOC, 0, 1'b0, 0, 0, 1, outcome(0, 0, 0, 0)));
    dir_rows.push_back(cmd_row(CMD_ALLOC, 255, 1'b1, 32767, 63, 1, outcome(0, 1, 0, 0)));
    dir_rows.push_back(cmd_row(CMD_TICK, 0, 1'b0, 0, 0, 1, outcome(0, 0, 0, 1)));
    dir_rows.push_back(cmd_row(CMD_TICK, 255, 1'b1, 32767, 63, 1, none));
    dir_rows.push_back(cmd_row(CMD_FREE, 0, 1'b0, 0, 63, 1, none));
    dir_rows.push_back(cmd_row(CMD_FREE, 0, 1'b0, 0, 1, 1, none));
    dir_rows.push_back(cmd_row(CMD_NOP, 255, 1'b1, 32767, 63, 1, none));
    dir_rows.push_back(cmd_row(CMD_ALLOC, 128, 1'b1, 5, 0, 1, outcome(0, 2, 0, 0)));
    // zero acts as a one-slot table; stale start wraps to slot 0
    dir_rows.push_back(cfg_row(0));
    dir_rows.push_back(cmd_row(CMD_ALLOC, 10, 1'b0, 3, 0, 1, outcome(0, 0, 0, 0)));
    dir_rows.push_back(cmd_row(CMD_ALLOC, 10, 1'b1, 3, 0, 1, outcome(0, 0, 1, 0)));
    // equal priority against a protected slot
    dir_rows.push_back(cmd_row(CMD_ALLOC, 10, 1'b0, 1, 0, 1, outcome(1, 0, 0, 0)));
    dir_rows.push_back(cmd_row(CMD_ALLOC, 11, 1'b0, 1, 0, 1, outcome(1, 0, 0, 0)));
    dir_rows.push_back(cmd_row(CMD_ALLOC, 9, 1'b0, 1, 0, 1, outcome(0, 0, 1, 0)));
    dir_rows.push_back(cmd_row(CMD_TICK, 0, 1'b0, 0, 0, 1, none));
    dir_rows.push_back(cmd_row(CMD_FREE, 0, 1'b0, 0, 2, 1, none));
    dir_rows.push_back(cfg_row(127));
    dir_rows.push_back(cmd_row(CMD_TICK, 0, 1'b0, 0, 0, 1, outcome(0, 0, 0, 1)));
    dir_rows.push_back(cmd_row(CMD_ALLOC, 128, 1'b0, 2, 0, 0, none));
    dir_rows.push_back(cmd_row(CMD_FREE, 0, 1'b0, 0, 0, 1, none));
    dir_rows.push_back(cfg_row(65));
    dir_rows.push_back(cmd_row(CMD_ALLOC, 200, 1'b1, 100, 0, 0, none));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg) begin
        drain_results();
        write_entries(dir_rows[r].cfg_val);
      end else begin
        send(dir_rows[r].cmd, dir_rows[r].typed, dir_rows[r].res);
      end
    end

    foreach (cfg_plan[p]) begin
      drain_results();
      write_entries(cfg_plan[p]);
      burst = ($urandom_range(0, 3) == 0);
      w_tick = $urandom_range(2, 25);
      draw = $urandom_range(0, 2);
      life_cap = (draw == 0) ? 3 : ((draw == 1) ? 30 : 500);
      prio_base = $urandom_range(0, 252);
      for (j = 0; j < PHASE_ITEMS; j++) begin
        draw = $urandom_range(0, 99);
        if (draw < w_tick) c.cmd = CMD_TICK;
        else if (draw < w_tick + 10) c.cmd = CMD_FREE;
        else if (draw < w_tick + 13) c.cmd = CMD_NOP;
        else c.cmd = CMD_ALLOC;
        draw = $urandom_range(0, 9);
        if (draw < 6) c.prio = 8'(prio_base + $urandom_range(0, 3));
        else if (draw == 6) c.prio = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        else c.prio = 8'($urandom_range(0, 255));
        c.prot = 1'($urandom_range(0, 1));
        c.life = ($urandom_range(0, 9) == 0) ? 15'($urandom_range(0, 32767))
                                             : 15'($urandom_range(0, life_cap));
        c.victim = 6'($urandom_range(0, MAX_SLOTS - 1));
        send(c, 1'b0, none);
      end
    end

    drain_results();
    repeat (MAX_SLOTS + 8) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS priority_slot_allocator");
    end else begin
      $display("FAIL priority_slot_allocator");
    end
    $finish;
  end

endmodule
